/* sv/acalt_pkg.sv */
`default_nettype none

package acalt_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    // only channels 0..3 feed an output: 0..2 errors, 3 the thermistor
    localparam int NUM_SUMS   = 4;
    localparam int NUM_ERRORS = 3;
    localparam int SENSOR_CH  = 3;

    localparam logic [2:0] ROUNDS_PER_WINDOW = 3'd4;
    localparam logic [7:0] SENSOR_CLAMP      = 8'd128;
    localparam logic [5:0] PERIOD_RESET      = 6'd38;
    localparam logic [6:0] F_INDEX_MAX       = 7'd100;

    localparam logic [7:0] MUX_CODES [0:3] = '{8'h83, 8'h85, 8'h87, 8'h8F};

    localparam logic [6:0] F_TABLE [0:128] = '{
        7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32,
        7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32,
        7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32,
        7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32,
        7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd33, 7'd34, 7'd35,
        7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd43,
        7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51,
        7'd52, 7'd53, 7'd53, 7'd54, 7'd55, 7'd56, 7'd56, 7'd57,
        7'd58, 7'd59, 7'd60, 7'd60, 7'd61, 7'd62, 7'd63, 7'd63,
        7'd64, 7'd65, 7'd66, 7'd67, 7'd68, 7'd68, 7'd69, 7'd70,
        7'd70, 7'd71, 7'd71, 7'd72, 7'd73, 7'd73, 7'd74, 7'd75,
        7'd75, 7'd76, 7'd77, 7'd77, 7'd78, 7'd79, 7'd79, 7'd80,
        7'd81, 7'd82, 7'd82, 7'd83, 7'd84, 7'd85, 7'd86, 7'd87,
        7'd88, 7'd88, 7'd89, 7'd90, 7'd91, 7'd91, 7'd92, 7'd92,
        7'd93, 7'd94, 7'd94, 7'd95, 7'd95, 7'd96, 7'd97, 7'd98,
        7'd98, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99
    };

    localparam logic [5:0] C_TABLE [0:100] = '{
        6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
        6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
        6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
        6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
        6'd0,  6'd0,  6'd1,  6'd2,  6'd2,  6'd3,  6'd3,  6'd4,
        6'd4,  6'd5,  6'd6,  6'd6,  6'd7,  6'd7,  6'd8,  6'd8,
        6'd9,  6'd9,  6'd10, 6'd11, 6'd11, 6'd12, 6'd12, 6'd13,
        6'd13, 6'd14, 6'd14, 6'd15, 6'd16, 6'd16, 6'd17, 6'd17,
        6'd18, 6'd18, 6'd19, 6'd19, 6'd20, 6'd21, 6'd21, 6'd22,
        6'd22, 6'd23, 6'd23, 6'd24, 6'd24, 6'd25, 6'd25, 6'd26,
        6'd26, 6'd27, 6'd28, 6'd28, 6'd29, 6'd29, 6'd30, 6'd31,
        6'd31, 6'd32, 6'd32, 6'd33, 6'd33, 6'd34, 6'd34, 6'd35,
        6'd36, 6'd36, 6'd37, 6'd37, 6'd37
    };

    typedef struct packed {
        logic [9:0] conversion;
        logic       heater_on;
    } item_t;

    typedef struct packed {
        logic [2:0]                     round_count;
        logic [NUM_SUMS-1:0][9:0]       sums;
        logic                           armed;
        logic [5:0]                     window_count;
        logic [NUM_ERRORS-1:0][7:0]     errors;
        logic [7:0]                     sensor;
        logic [6:0]                     fahr;
        logic [5:0]                     cels;
    } state_t;

    typedef struct packed {
        logic win;
        logic errs;
        logic disp;
    } flags_t;

    typedef struct packed {
        logic [7:0] next_channel_code;
        logic       window_done;
        logic       errors_updated;
        logic [7:0] error_avg_a;
        logic [7:0] error_avg_b;
        logic [7:0] error_avg_c;
        logic [7:0] sensor_avg;
        logic       display_updated;
        logic [6:0] fahrenheit;
        logic [5:0] celsius;
    } result_t;

    // channels past the fourth share the last code
    function automatic logic [7:0] mux_code(input logic [2:0] idx);
        logic [7:0] code;
        if (idx < 3'd4)
        begin
            code = MUX_CODES[idx[1:0]];
        end
        else
        begin
            code = MUX_CODES[3];
        end
        return code;
    endfunction

    function automatic logic [5:0] celsius_of(input logic [6:0] fahr);
        logic [6:0] idx;
        idx = (fahr > F_INDEX_MAX) ? F_INDEX_MAX : fahr;
        return C_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

/* sv/acalt_if.sv */
`default_nettype none

interface acalt_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] conversion;
    logic       heater_on;

    modport source (output valid, output conversion, output heater_on, input ready);
    modport sink   (input valid, input conversion, input heater_on, output ready);
endinterface

interface acalt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] next_channel_code;
    logic       window_done;
    logic       errors_updated;
    logic [7:0] error_avg_a;
    logic [7:0] error_avg_b;
    logic [7:0] error_avg_c;
    logic [7:0] sensor_avg;
    logic       display_updated;
    logic [6:0] fahrenheit;
    logic [5:0] celsius;

    modport source (
        output valid, output next_channel_code, output window_done,
        output errors_updated, output error_avg_a, output error_avg_b,
        output error_avg_c, output sensor_avg, output display_updated,
        output fahrenheit, output celsius, input ready
    );
    modport sink (
        input valid, input next_channel_code, input window_done,
        input errors_updated, input error_avg_a, input error_avg_b,
        input error_avg_c, input sensor_avg, input display_updated,
        input fahrenheit, input celsius, output ready
    );
endinterface

`default_nettype wire

/* sv/acalt_step.sv */
`default_nettype none

module acalt_step #(
    parameter int NUM_CHANNELS = acalt_pkg::NUM_CHANNELS_DEF,
    localparam int CH_W = $clog2(NUM_CHANNELS)
) (
    input  acalt_pkg::item_t  item,
    input  logic [5:0]        display_period,
    input  logic [CH_W-1:0]   ch_idx,
    input  acalt_pkg::state_t st,
    output logic [CH_W-1:0]   ch_next,
    output acalt_pkg::state_t st_next,
    output acalt_pkg::flags_t flags
);
    import acalt_pkg::*;

    logic [7:0]               sample;
    logic [NUM_SUMS-1:0][9:0] sums_add;
    logic                     wrap;
    logic [2:0]               round_inc;
    logic                     armed_now;
    logic [7:0]               sensor_raw;
    logic [7:0]               sensor_clamped;
    logic [6:0]               fahr_lookup;
    logic [5:0]               window_inc;

    always_comb
    begin
        sample = item.conversion[9:2];
        for (int i = 0; i < NUM_SUMS; i++)
        begin
            sums_add[i] = st.sums[i] + ((int'(ch_idx) == i) ? {2'b00, sample} : 10'd0);
        end

        wrap       = (int'(ch_idx) >= NUM_CHANNELS - 1);
        ch_next    = wrap ? '0 : CH_W'(ch_idx + 1'b1);
        round_inc  = wrap ? 3'(st.round_count + 3'd1) : st.round_count;
        armed_now  = st.armed & item.heater_on;

        sensor_raw     = sums_add[SENSOR_CH][9:2];
        sensor_clamped = (sensor_raw > SENSOR_CLAMP) ? SENSOR_CLAMP : sensor_raw;
        fahr_lookup    = F_TABLE[sensor_clamped];
        window_inc     = 6'(st.window_count + 6'd1);

        st_next             = st;
        st_next.sums        = sums_add;
        st_next.round_count = round_inc;
        st_next.armed       = armed_now;
        flags               = '0;

        if (round_inc == ROUNDS_PER_WINDOW)
        begin
            flags.win = 1'b1;
            if (armed_now)
            begin
                for (int i = 0; i < NUM_ERRORS; i++)
                begin
                    st_next.errors[i] = sums_add[i][9:2];
                end
                flags.errs = 1'b1;
            end
            st_next.sensor       = sensor_clamped;
            st_next.sums         = '0;
            st_next.round_count  = '0;
            st_next.armed        = 1'b1;
            st_next.window_count = window_inc;
            if (window_inc == 6'd1)
            begin
                st_next.fahr = fahr_lookup;
                st_next.cels = celsius_of(fahr_lookup);
                flags.disp   = 1'b1;
            end
            else if (window_inc > display_period)
            begin
                st_next.window_count = '0;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/adc_channel_average_temp_lookup.sv */
// an accepted word is held in the input register, then its result in the result register
// throughput: one word per cycle; the input register feeds the single update stage
// and the result register decouples the output side, so input stalls only on backpressure
// reset (rst_n, async, active low): channel 0, all sums, error, sensor and temperature
// values cleared, error check disarmed, display_period back to 38
`default_nettype none

module adc_channel_average_temp_lookup #(
    parameter int NUM_CHANNELS = acalt_pkg::NUM_CHANNELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [5:0]        cfg_data,
    acalt_in_if.sink          sample,
    acalt_out_if.source       result
);
    import acalt_pkg::*;

    localparam int CH_W = $clog2(NUM_CHANNELS);

    // input register
    item_t           in_reg;
    logic            in_valid_reg;

    // running state: channel pointer, sums, window bookkeeping, held values
    logic [CH_W-1:0] ch_reg;
    state_t          st_reg;
    logic [5:0]      period_reg;

    // result register
    result_t         res_reg;
    logic            out_valid_reg;

    logic [CH_W-1:0] ch_next;
    state_t          st_next;
    flags_t          flags;
    result_t         res_next;
    logic            advance;
    logic            take;

    // the item in the input register moves on whenever the result slot is free
    // or being emptied this cycle
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    acalt_step #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_step (
        .item           (in_reg),
        .display_period (period_reg),
        .ch_idx         (ch_reg),
        .st             (st_reg),
        .ch_next        (ch_next),
        .st_next        (st_next),
        .flags          (flags)
    );

    // result word: code of the channel converted next, the update flags and all held values
    always_comb
    begin
        res_next.next_channel_code = mux_code(3'(ch_next));
        res_next.window_done       = flags.win;
        res_next.errors_updated    = flags.errs;
        res_next.error_avg_a       = st_next.errors[0];
        res_next.error_avg_b       = st_next.errors[1];
        res_next.error_avg_c       = st_next.errors[2];
        res_next.sensor_avg        = st_next.sensor;
        res_next.display_updated   = flags.disp;
        res_next.fahrenheit        = st_next.fahr;
        res_next.celsius           = st_next.cels;
    end

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
            st_reg        <= '0;
            period_reg    <= PERIOD_RESET;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                ch_reg        <= ch_next;
                st_reg        <= st_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                period_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg.conversion <= sample.conversion;
            in_reg.heater_on  <= sample.heater_on;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.next_channel_code = res_reg.next_channel_code;
    assign result.window_done       = res_reg.window_done;
    assign result.errors_updated    = res_reg.errors_updated;
    assign result.error_avg_a       = res_reg.error_avg_a;
    assign result.error_avg_b       = res_reg.error_avg_b;
    assign result.error_avg_c       = res_reg.error_avg_c;
    assign result.sensor_avg        = res_reg.sensor_avg;
    assign result.display_updated   = res_reg.display_updated;
    assign result.fahrenheit        = res_reg.fahrenheit;
    assign result.celsius           = res_reg.celsius;

    // a completed window restarts the round count
    a_window_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && flags.win |=> st_reg.round_count == 3'd0)
        else $error("round count not cleared after window");

    // a display refresh only happens on the first window of a display cycle
    a_disp_first_window: assert property (@(posedge clk) disable iff (!rst_n)
        advance && flags.disp |=> st_reg.window_count == 6'd1)
        else $error("display refresh outside first window");

    // held thermistor average never passes the clamp
    a_sensor_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.sensor <= SENSOR_CLAMP)
        else $error("sensor average above clamp");

    // a waiting item is neither lost nor overwritten
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("pending item disturbed");

endmodule

`default_nettype wire
